// ----- src/sbag_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbag_pkg
// shared widths, register map, pipeline types and helpers for the scaled
// blit address generator
// ---------------------------------------------------------------------------
package sbag_pkg;

    localparam int COORD_BITS = 16;
    localparam int ADDR_BITS  = 32;

    localparam int OFF_W      = 15;
    localparam int OUT_W      = 16;
    localparam int ADDR_OUT_W = 32;
    localparam int XW         = 18;
    localparam int PW         = OFF_W + COORD_BITS;
    localparam int QI         = 16;
    localparam int Q_W        = QI + 1;
    localparam int DIV_ST     = QI + 1;
    localparam int N_ST       = DIV_ST + 4;
    localparam int PROD_W     = COORD_BITS + 16;
    localparam int OFS_W      = COORD_BITS + 2;
    localparam int SUM_W      = (PROD_W + 1 > ADDR_BITS) ? PROD_W + 1 : ADDR_BITS;

    localparam int DATA_W  = 64;
    localparam int PADDR_W = 6;
    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SRC_ORIGIN = 3'd0,
        REG_SRC_EXTENT = 3'd1,
        REG_DST_ORIGIN = 3'd2,
        REG_DST_EXTENT = 3'd3,
        REG_SRC_GEOM   = 3'd4,
        REG_DST_GEOM   = 3'd5,
        REG_SRC_PITCH  = 3'd6,
        REG_DST_PITCH  = 3'd7
    } reg_idx_t;

    localparam logic [1:0] BPP_1    = 2'd0;
    localparam logic [1:0] BPP_2    = 2'd1;
    localparam logic [1:0] BPP_4    = 2'd2;
    // spare code, handled as four bytes per pixel
    localparam logic [1:0] BPP_RSVD = 2'd3;

    typedef struct packed {
        logic [31:0] src_origin;
        logic [31:0] src_extent;
        logic [31:0] dst_origin;
        logic [31:0] dst_extent;
        logic [33:0] src_geom;
        logic [33:0] dst_geom;
        logic [15:0] src_pitch;
        logic [15:0] dst_pitch;
    } cfg_t;

    typedef struct packed {
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic                 in_rect;
    } side_t;

    typedef struct packed {
        side_t                 side;
        logic [PW-1:0]         prod_x;
        logic [PW-1:0]         prod_y;
        logic [COORD_BITS-1:0] dw;
        logic [COORD_BITS-1:0] dh;
    } front_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] rem;
        logic [QI-1:0]         low;
        logic [QI-1:0]         q;
        logic                  ovf;
        logic                  zero;
        logic [COORD_BITS-1:0] dvs;
    } div_lane_t;

    typedef struct packed {
        div_lane_t x;
        div_lane_t y;
        side_t     side;
    } div_stage_t;

    typedef struct packed {
        logic [Q_W-1:0] q_x;
        logic [Q_W-1:0] q_y;
        side_t          side;
    } div_out_t;

    typedef struct packed {
        logic [OUT_W-1:0] src_col;
        logic [OUT_W-1:0] src_row;
        logic [OUT_W-1:0] dst_col;
        logic [OUT_W-1:0] dst_row;
        logic [ADDR_OUT_W-1:0] src_addr;
        logic [ADDR_OUT_W-1:0] dst_addr;
        logic pair_valid;
    } out_t;

    function automatic logic [COORD_BITS-1:0] fld_lo(input logic [31:0] r);
        return r[COORD_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] fld_hi(input logic [31:0] r);
        return r[16 +: COORD_BITS];
    endfunction

    // sign-extend a coordinate field to the working width
    function automatic logic signed [XW-1:0] fld_sext(input logic [COORD_BITS-1:0] f);
        return XW'($signed(f));
    endfunction

    function automatic logic [OUT_W-1:0] sat16(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi_lim;
        logic signed [XW-1:0] lo_lim;
        hi_lim = XW'(32767);
        lo_lim = -XW'(32768);
        if (v > hi_lim)
            return 16'h7fff;
        else if (v < lo_lim)
            return 16'h8000;
        else
            return v[OUT_W-1:0];
    endfunction

    function automatic logic [1:0] bpp_shift(input logic [1:0] code);
        case (code)
            BPP_1:   return 2'd0;
            BPP_2:   return 2'd1;
            default: return 2'd2;
        endcase
    endfunction

endpackage

// ----- src/sbag_regs.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbag_regs
// apb configuration registers, 64-bit data, one register per 8 bytes
// ---------------------------------------------------------------------------
module sbag_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbag_pkg::PADDR_W-1:0]  paddr,
    input  logic [sbag_pkg::DATA_W-1:0]   pwdata,
    output logic [sbag_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output sbag_pkg::cfg_t                cfg
);
    import sbag_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:PADDR_W-REG_IDX_W]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr)
        begin
            case (idx)
                REG_SRC_ORIGIN: cfg_reg.src_origin <= pwdata[31:0];
                REG_SRC_EXTENT: cfg_reg.src_extent <= pwdata[31:0];
                REG_DST_ORIGIN: cfg_reg.dst_origin <= pwdata[31:0];
                REG_DST_EXTENT: cfg_reg.dst_extent <= pwdata[31:0];
                REG_SRC_GEOM:   cfg_reg.src_geom   <= pwdata[33:0];
                REG_DST_GEOM:   cfg_reg.dst_geom   <= pwdata[33:0];
                REG_SRC_PITCH:  cfg_reg.src_pitch  <= pwdata[15:0];
                REG_DST_PITCH:  cfg_reg.dst_pitch  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SRC_ORIGIN: prdata = DATA_W'(cfg_reg.src_origin);
            REG_SRC_EXTENT: prdata = DATA_W'(cfg_reg.src_extent);
            REG_DST_ORIGIN: prdata = DATA_W'(cfg_reg.dst_origin);
            REG_DST_EXTENT: prdata = DATA_W'(cfg_reg.dst_extent);
            REG_SRC_GEOM:   prdata = DATA_W'(cfg_reg.src_geom);
            REG_DST_GEOM:   prdata = DATA_W'(cfg_reg.dst_geom);
            REG_SRC_PITCH:  prdata = DATA_W'(cfg_reg.src_pitch);
            REG_DST_PITCH:  prdata = DATA_W'(cfg_reg.dst_pitch);
            default:        prdata = '0;
        endcase
    end

endmodule

// ----- src/sbag_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbag_front
// first stage: effective extents, destination coordinate, scaling products
// ---------------------------------------------------------------------------
module sbag_front (
    input  logic                        clk,
    input  logic                        en,
    input  logic [sbag_pkg::OFF_W-1:0]  col_offset,
    input  logic [sbag_pkg::OFF_W-1:0]  row_offset,
    input  sbag_pkg::cfg_t              cfg,
    output sbag_pkg::front_t            front
);
    import sbag_pkg::*;

    front_t                front_reg;
    front_t                front_next;
    logic [COORD_BITS-1:0] sw;
    logic [COORD_BITS-1:0] sh;
    logic [COORD_BITS-1:0] dw;
    logic [COORD_BITS-1:0] dh;

    always_comb
    begin
        sw = fld_lo(cfg.src_extent);
        sh = fld_hi(cfg.src_extent);
        dw = fld_lo(cfg.dst_extent);
        dh = fld_hi(cfg.dst_extent);
        // zero destination extent falls back to the source extent
        if (dw == '0)
            dw = sw;
        if (dh == '0)
            dh = sh;

        front_next.dw     = dw;
        front_next.dh     = dh;
        front_next.prod_x = PW'(col_offset) * PW'(sw);
        front_next.prod_y = PW'(row_offset) * PW'(sh);
        front_next.side.dx = fld_sext(fld_lo(cfg.dst_origin)) + $signed(XW'(col_offset));
        front_next.side.dy = fld_sext(fld_hi(cfg.dst_origin)) + $signed(XW'(row_offset));
        front_next.side.in_rect = (sw != '0) && (sh != '0)
            && (XW'(col_offset) < XW'(dw)) && (XW'(row_offset) < XW'(dh));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            front_reg <= front_next;
    end

    assign front = front_reg;

endmodule

// ----- src/sbag_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbag_div
// pipelined restoring divider, two lanes, one quotient bit per stage;
// quotient saturates at 2^16, which already saturates every output coordinate
// ---------------------------------------------------------------------------
module sbag_div (
    input  logic                        clk,
    input  logic [sbag_pkg::DIV_ST-1:0] en,
    input  sbag_pkg::front_t            front,
    output sbag_pkg::div_out_t          dout
);
    import sbag_pkg::*;

    div_stage_t st_reg  [DIV_ST];
    div_stage_t st_next [DIV_ST];

    function automatic div_lane_t lane_init(input logic [PW-1:0] dvd,
                                            input logic [COORD_BITS-1:0] dvs);
        div_lane_t l;
        l.dvs  = dvs;
        l.zero = (dvs == '0);
        l.rem  = COORD_BITS'(dvd[PW-1:QI]);
        l.ovf  = (COORD_BITS'(dvd[PW-1:QI]) >= dvs);
        l.low  = dvd[QI-1:0];
        l.q    = '0;
        return l;
    endfunction

    function automatic div_lane_t lane_step(input div_lane_t l);
        div_lane_t           n;
        logic [COORD_BITS:0] r2;
        logic [COORD_BITS:0] diff;
        logic                ge;
        n    = l;
        r2   = {l.rem, l.low[QI-1]};
        diff = r2 - {1'b0, l.dvs};
        ge   = (r2 >= {1'b0, l.dvs});
        n.rem = ge ? diff[COORD_BITS-1:0] : r2[COORD_BITS-1:0];
        n.low = {l.low[QI-2:0], 1'b0};
        n.q   = {l.q[QI-2:0], ge};
        return n;
    endfunction

    function automatic logic [Q_W-1:0] lane_quot(input div_lane_t l);
        if (l.zero)
            return '0;
        else if (l.ovf)
            return Q_W'(1) << QI;
        else
            return {1'b0, l.q};
    endfunction

    always_comb
    begin
        st_next[0].x    = lane_init(front.prod_x, front.dw);
        st_next[0].y    = lane_init(front.prod_y, front.dh);
        st_next[0].side = front.side;
        for (int k = 1; k < DIV_ST; k++)
        begin
            st_next[k].x    = lane_step(st_reg[k-1].x);
            st_next[k].y    = lane_step(st_reg[k-1].y);
            st_next[k].side = st_reg[k-1].side;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_ST; k++)
        begin
            if (en[k])
                st_reg[k] <= st_next[k];
        end
    end

    assign dout.q_x  = lane_quot(st_reg[DIV_ST-1].x);
    assign dout.q_y  = lane_quot(st_reg[DIV_ST-1].y);
    assign dout.side = st_reg[DIV_ST-1].side;

endmodule

// ----- src/sbag_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbag_back
// source coordinate, clipping, pitch multiply and address add, output stage
// ---------------------------------------------------------------------------
module sbag_back (
    input  logic                 clk,
    input  logic [2:0]           en,
    input  sbag_pkg::cfg_t       cfg,
    input  sbag_pkg::div_out_t   din,
    output sbag_pkg::out_t       dout
);
    import sbag_pkg::*;

    typedef struct packed {
        logic                  valid;
        logic [OUT_W-1:0]      sx_o;
        logic [OUT_W-1:0]      sy_o;
        logic [OUT_W-1:0]      dx_o;
        logic [OUT_W-1:0]      dy_o;
        logic [COORD_BITS-1:0] sx_u;
        logic [COORD_BITS-1:0] sy_u;
        logic [COORD_BITS-1:0] dx_u;
        logic [COORD_BITS-1:0] dy_u;
    } back_a_t;

    typedef struct packed {
        logic              valid;
        logic [OUT_W-1:0]  sx_o;
        logic [OUT_W-1:0]  sy_o;
        logic [OUT_W-1:0]  dx_o;
        logic [OUT_W-1:0]  dy_o;
        logic [PROD_W-1:0] s_prod;
        logic [OFS_W-1:0]  s_ofs;
        logic [PROD_W-1:0] d_prod;
        logic [OFS_W-1:0]  d_ofs;
    } back_b_t;

    back_a_t a_reg;
    back_a_t a_next;
    back_b_t b_reg;
    back_b_t b_next;
    out_t    o_reg;
    out_t    o_next;

    logic signed [XW-1:0] sx;
    logic signed [XW-1:0] sy;
    logic [SUM_W-1:0]     s_sum;
    logic [SUM_W-1:0]     d_sum;

    // stage a: source coordinate and clip against both surfaces
    always_comb
    begin
        sx = fld_sext(fld_lo(cfg.src_origin)) + $signed(XW'(din.q_x));
        sy = fld_sext(fld_hi(cfg.src_origin)) + $signed(XW'(din.q_y));

        a_next.valid = din.side.in_rect
            && !din.side.dx[XW-1] && (din.side.dx < $signed(XW'(fld_lo(cfg.dst_geom[31:0]))))
            && !din.side.dy[XW-1] && (din.side.dy < $signed(XW'(fld_hi(cfg.dst_geom[31:0]))))
            && !sx[XW-1] && (sx < $signed(XW'(fld_lo(cfg.src_geom[31:0]))))
            && !sy[XW-1] && (sy < $signed(XW'(fld_hi(cfg.src_geom[31:0]))));
        a_next.sx_o = sat16(sx);
        a_next.sy_o = sat16(sy);
        a_next.dx_o = sat16(din.side.dx);
        a_next.dy_o = sat16(din.side.dy);
        a_next.sx_u = sx[COORD_BITS-1:0];
        a_next.sy_u = sy[COORD_BITS-1:0];
        a_next.dx_u = din.side.dx[COORD_BITS-1:0];
        a_next.dy_u = din.side.dy[COORD_BITS-1:0];
    end

    // stage b: row times pitch, column times bytes per pixel
    always_comb
    begin
        b_next.valid  = a_reg.valid;
        b_next.sx_o   = a_reg.sx_o;
        b_next.sy_o   = a_reg.sy_o;
        b_next.dx_o   = a_reg.dx_o;
        b_next.dy_o   = a_reg.dy_o;
        b_next.s_prod = PROD_W'(a_reg.sy_u) * PROD_W'(cfg.src_pitch);
        b_next.d_prod = PROD_W'(a_reg.dy_u) * PROD_W'(cfg.dst_pitch);
        b_next.s_ofs  = OFS_W'(a_reg.sx_u) << bpp_shift(cfg.src_geom[33:32]);
        b_next.d_ofs  = OFS_W'(a_reg.dx_u) << bpp_shift(cfg.dst_geom[33:32]);
    end

    // stage c: address add, zero for an invalid pair
    always_comb
    begin
        s_sum = SUM_W'(b_reg.s_prod) + SUM_W'(b_reg.s_ofs);
        d_sum = SUM_W'(b_reg.d_prod) + SUM_W'(b_reg.d_ofs);
        o_next.pair_valid = b_reg.valid;
        o_next.src_col    = b_reg.sx_o;
        o_next.src_row    = b_reg.sy_o;
        o_next.dst_col    = b_reg.dx_o;
        o_next.dst_row    = b_reg.dy_o;
        o_next.src_addr   = b_reg.valid ? ADDR_OUT_W'(s_sum[ADDR_BITS-1:0]) : '0;
        o_next.dst_addr   = b_reg.valid ? ADDR_OUT_W'(d_sum[ADDR_BITS-1:0]) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            a_reg <= a_next;
        if (en[1])
            b_reg <= b_next;
        if (en[2])
            o_reg <= o_next;
    end

    assign dout = o_reg;

endmodule

// ----- src/scaled_blit_address_generator.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scaled_blit_address_generator
// nearest-neighbor scaled blit: source and destination pixel coordinates,
// clipping and byte addresses for one destination pixel per beat
// ---------------------------------------------------------------------------
// pipeline: front stage, then the 17-stage divider (one overflow stage plus
//   one quotient bit per stage), then back stages a, b and c
// throughput: one beat per cycle, out_ready high; bubbles collapse on stall
// reset: rst_n clears all stage valid bits and the configuration registers
// ---------------------------------------------------------------------------
module scaled_blit_address_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbag_pkg::PADDR_W-1:0]  paddr,
    input  logic [sbag_pkg::DATA_W-1:0]   pwdata,
    output logic [sbag_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sbag_pkg::OFF_W-1:0]    col_offset,
    input  logic [sbag_pkg::OFF_W-1:0]    row_offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          pair_valid,
    output logic signed [sbag_pkg::OUT_W-1:0]   src_col,
    output logic signed [sbag_pkg::OUT_W-1:0]   src_row,
    output logic signed [sbag_pkg::OUT_W-1:0]   dst_col,
    output logic signed [sbag_pkg::OUT_W-1:0]   dst_row,
    output logic [sbag_pkg::ADDR_OUT_W-1:0]     src_addr,
    output logic [sbag_pkg::ADDR_OUT_W-1:0]     dst_addr
);
    import sbag_pkg::*;

    cfg_t     cfg;
    front_t   front;
    div_out_t dq;
    out_t     res;

    logic [N_ST-1:0] valid_reg;
    logic [N_ST-1:0] valid_next;
    logic [N_ST-1:0] en;

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        en[N_ST-1] = !valid_reg[N_ST-1] || out_ready;
        for (int k = N_ST - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];

        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < N_ST; k++)
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    sbag_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sbag_front u_front (
        .clk        (clk),
        .en         (en[0]),
        .col_offset (col_offset),
        .row_offset (row_offset),
        .cfg        (cfg),
        .front      (front)
    );

    sbag_div u_div (
        .clk   (clk),
        .en    (en[DIV_ST:1]),
        .front (front),
        .dout  (dq)
    );

    sbag_back u_back (
        .clk  (clk),
        .en   (en[N_ST-1:N_ST-3]),
        .cfg  (cfg),
        .din  (dq),
        .dout (res)
    );

    assign in_ready   = en[0];
    assign out_valid  = valid_reg[N_ST-1];
    assign pair_valid = res.pair_valid;
    assign src_col    = $signed(res.src_col);
    assign src_row    = $signed(res.src_row);
    assign dst_col    = $signed(res.dst_col);
    assign dst_row    = $signed(res.dst_row);
    assign src_addr   = res.src_addr;
    assign dst_addr   = res.dst_addr;

endmodule

// ----- sim/scaled_blit_address_generator_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scaled_blit_address_generator_tb
// drives destination offsets through the valid/ready input, reprograms the
// configuration registers over apb between phases, and checks every output
// beat field by field against an in-order queue of predicted coordinate pairs
// ---------------------------------------------------------------------------
module scaled_blit_address_generator_tb;

    import sbag_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_STALL  = 300;
    localparam int RANDOM_BEATS = 950;

    typedef struct packed {
        logic [OFF_W-1:0] col;
        logic [OFF_W-1:0] row;
    } offset_beat_t;

    typedef struct packed {
        logic                  pair_valid;
        logic [OUT_W-1:0]      src_col;
        logic [OUT_W-1:0]      src_row;
        logic [OUT_W-1:0]      dst_col;
        logic [OUT_W-1:0]      dst_row;
        logic [ADDR_OUT_W-1:0] src_addr;
        logic [ADDR_OUT_W-1:0] dst_addr;
    } pixel_pair_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [OFF_W-1:0]      col_offset = '0;
    logic [OFF_W-1:0]      row_offset = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  pair_valid;
    logic signed [OUT_W-1:0] src_col;
    logic signed [OUT_W-1:0] src_row;
    logic signed [OUT_W-1:0] dst_col;
    logic signed [OUT_W-1:0] dst_row;
    logic [ADDR_OUT_W-1:0] src_addr;
    logic [ADDR_OUT_W-1:0] dst_addr;

    cfg_t          cfg_shadow = '0;
    offset_beat_t  pending_beats[$];
    pixel_pair_t   expected_pairs[$];
    logic          in_beat_taken = 1'b0;
    int            mismatches = 0;
    int            cycle_count = 0;
    bit            steady = 1'b0;
    bit            stall_arm = 1'b0;
    bit            stall_done = 1'b0;
    int            stall_left = 0;

    scaled_blit_address_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .col_offset (col_offset),
        .row_offset (row_offset),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pair_valid (pair_valid),
        .src_col    (src_col),
        .src_row    (src_row),
        .dst_col    (dst_col),
        .dst_row    (dst_row),
        .src_addr   (src_addr),
        .dst_addr   (dst_addr)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    function automatic longint half_unsigned(input logic [31:0] r, input bit upper);
        return upper ? longint'(r[31:16]) : longint'(r[15:0]);
    endfunction

    function automatic longint half_signed(input logic [31:0] r, input bit upper);
        logic signed [15:0] h;
        h = upper ? r[31:16] : r[15:0];
        return longint'(h);
    endfunction

    function automatic longint bpp_bytes(input logic [1:0] code);
        if (code == BPP_1)
            return 1;
        else if (code == BPP_2)
            return 2;
        return 4;
    endfunction

    function automatic logic [OUT_W-1:0] clamp_coord(input longint v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[OUT_W-1:0];
    endfunction

    // nearest-neighbor mapping of one destination offset under cfg_shadow
    function automatic pixel_pair_t predict_pair(input logic [OFF_W-1:0] col,
                                                 input logic [OFF_W-1:0] row);
        longint ox, oy, sw, sh, dw, dh;
        longint dx, dy, sx, sy;
        longint ssw, ssh, dsw, dsh;
        longint sa, da;
        bit ok;
        pixel_pair_t p;
        ox  = longint'(col);
        oy  = longint'(row);
        sw  = half_unsigned(cfg_shadow.src_extent, 1'b0);
        sh  = half_unsigned(cfg_shadow.src_extent, 1'b1);
        dw  = half_unsigned(cfg_shadow.dst_extent, 1'b0);
        dh  = half_unsigned(cfg_shadow.dst_extent, 1'b1);
        ssw = half_unsigned(cfg_shadow.src_geom[31:0], 1'b0);
        ssh = half_unsigned(cfg_shadow.src_geom[31:0], 1'b1);
        dsw = half_unsigned(cfg_shadow.dst_geom[31:0], 1'b0);
        dsh = half_unsigned(cfg_shadow.dst_geom[31:0], 1'b1);
        if (dw == 0)
            dw = sw;
        if (dh == 0)
            dh = sh;
        dx = half_signed(cfg_shadow.dst_origin, 1'b0) + ox;
        dy = half_signed(cfg_shadow.dst_origin, 1'b1) + oy;
        sx = half_signed(cfg_shadow.src_origin, 1'b0) + ((dw != 0) ? (ox * sw) / dw : 0);
        sy = half_signed(cfg_shadow.src_origin, 1'b1) + ((dh != 0) ? (oy * sh) / dh : 0);
        ok = sw != 0 && sh != 0 && ox < dw && oy < dh &&
             dx >= 0 && dx < dsw && dy >= 0 && dy < dsh &&
             sx >= 0 && sx < ssw && sy >= 0 && sy < ssh;
        sa = 0;
        da = 0;
        if (ok)
        begin
            sa = sy * longint'(cfg_shadow.src_pitch) +
                 sx * bpp_bytes(cfg_shadow.src_geom[33:32]);
            da = dy * longint'(cfg_shadow.dst_pitch) +
                 dx * bpp_bytes(cfg_shadow.dst_geom[33:32]);
        end
        p.pair_valid = ok;
        p.src_col    = clamp_coord(sx);
        p.src_row    = clamp_coord(sy);
        p.dst_col    = clamp_coord(dx);
        p.dst_row    = clamp_coord(dy);
        p.src_addr   = sa[ADDR_OUT_W-1:0];
        p.dst_addr   = da[ADDR_OUT_W-1:0];
        return p;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    // input beats become predictions, output beats are checked in order
    always @(posedge clk)
    begin
        pixel_pair_t want;
        if (!rst_n)
            in_beat_taken <= 1'b0;
        else
        begin
            in_beat_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                expected_pairs.push_back(predict_pair(col_offset, row_offset));
            if (out_valid && out_ready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    $error("output beat with no prediction pending");
                    mismatches++;
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    compare_field("pair_valid", 32'(want.pair_valid), 32'(pair_valid));
                    compare_field("src_col", 32'(want.src_col), 32'($unsigned(src_col)));
                    compare_field("src_row", 32'(want.src_row), 32'($unsigned(src_row)));
                    compare_field("dst_col", 32'(want.dst_col), 32'($unsigned(dst_col)));
                    compare_field("dst_row", 32'(want.dst_row), 32'($unsigned(dst_row)));
                    compare_field("src_addr", want.src_addr, src_addr);
                    compare_field("dst_addr", want.dst_addr, dst_addr);
                end
            end
        end
    end

    // offset driver
    always @(negedge clk)
    begin
        offset_beat_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_beat_taken)
        begin
            if (pending_beats.size() != 0 && (steady || $urandom_range(99) >= 21))
            begin
                nxt = pending_beats.pop_front();
                col_offset <= nxt.col;
                row_offset <= nxt.row;
                in_valid   <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result sink, with one long hold-off once armed
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (stall_arm && !stall_done)
        begin
            stall_left <= LONG_STALL;
            stall_done <= 1'b1;
            out_ready  <= 1'b0;
        end
        else
            out_ready <= steady || ($urandom_range(99) >= 21);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** scaled_blit_address_generator: FAILED **");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_valid || expected_pairs.size() != 0)
            @(negedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_SRC_ORIGIN: cfg_shadow.src_origin = value[31:0];
            REG_SRC_EXTENT: cfg_shadow.src_extent = value[31:0];
            REG_DST_ORIGIN: cfg_shadow.dst_origin = value[31:0];
            REG_DST_EXTENT: cfg_shadow.dst_extent = value[31:0];
            REG_SRC_GEOM:   cfg_shadow.src_geom   = value[33:0];
            REG_DST_GEOM:   cfg_shadow.dst_geom   = value[33:0];
            REG_SRC_PITCH:  cfg_shadow.src_pitch  = value[15:0];
            REG_DST_PITCH:  cfg_shadow.dst_pitch  = value[15:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_setup(input cfg_t c);
        wait_idle();
        apb_write(REG_SRC_ORIGIN, 64'(c.src_origin));
        apb_write(REG_SRC_EXTENT, 64'(c.src_extent));
        apb_write(REG_DST_ORIGIN, 64'(c.dst_origin));
        apb_write(REG_DST_EXTENT, 64'(c.dst_extent));
        apb_write(REG_SRC_GEOM, 64'(c.src_geom));
        apb_write(REG_DST_GEOM, 64'(c.dst_geom));
        apb_write(REG_SRC_PITCH, 64'(c.src_pitch));
        apb_write(REG_DST_PITCH, 64'(c.dst_pitch));
    endtask

    task automatic push_offset(input int col, input int row);
        offset_beat_t b;
        b.col = OFF_W'(col);
        b.row = OFF_W'(row);
        pending_beats.push_back(b);
    endtask

    // small surfaces and rectangles so that most offsets land on real pixels
    function automatic cfg_t tidy_setup();
        int ssw, ssh, dsw, dsh;
        logic [1:0] sc, dc;
        cfg_t c;
        ssw = $urandom_range(160, 1);
        ssh = $urandom_range(120, 1);
        dsw = $urandom_range(240, 1);
        dsh = $urandom_range(180, 1);
        sc  = 2'($urandom_range(3, 0));
        dc  = 2'($urandom_range(3, 0));
        c.src_geom   = {sc, 16'(ssh), 16'(ssw)};
        c.dst_geom   = {dc, 16'(dsh), 16'(dsw)};
        c.src_extent = {16'($urandom_range(ssh, 1)), 16'($urandom_range(ssw, 1))};
        if ($urandom_range(19) == 0)
            c.src_extent[15:0] = '0;
        c.dst_extent = {16'($urandom_range(2 * ssh, 1)), 16'($urandom_range(2 * ssw, 1))};
        if ($urandom_range(4) == 0)
            c.dst_extent[15:0] = '0;
        if ($urandom_range(4) == 0)
            c.dst_extent[31:16] = '0;
        c.src_origin = {16'(int'($urandom_range(12, 0)) - 4),
                        16'(int'($urandom_range(12, 0)) - 4)};
        c.dst_origin = {16'(int'($urandom_range(dsh, 0)) - 6),
                        16'(int'($urandom_range(dsw, 0)) - 6)};
        c.src_pitch  = 16'(ssw * 4 + int'($urandom_range(32, 0)));
        c.dst_pitch  = 16'(dsw * 4 + int'($urandom_range(32, 0)));
        if ($urandom_range(9) == 0)
            c.src_pitch = 16'($urandom);
        if ($urandom_range(9) == 0)
            c.dst_pitch = 16'($urandom);
        return c;
    endfunction

    function automatic cfg_t wild_setup();
        cfg_t c;
        c.src_origin = $urandom;
        c.src_extent = $urandom;
        c.dst_origin = $urandom;
        c.dst_extent = $urandom;
        c.src_geom   = {2'($urandom), 32'($urandom)};
        c.dst_geom   = {2'($urandom), 32'($urandom)};
        c.src_pitch  = 16'($urandom);
        c.dst_pitch  = 16'($urandom);
        return c;
    endfunction

    // mostly offsets within or just past the rectangle, some anywhere in the field
    function automatic int pick_offset(input int span);
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return int'(15'($urandom));
        if (r < 14)
            return 0;
        if (r < 16)
            return 32767;
        if (span > 32766)
            span = 32766;
        return $urandom_range(span + 1, 0);
    endfunction

    task automatic queue_phase(input int n);
        int span_x, span_y;
        span_x = int'(cfg_shadow.dst_extent[15:0]);
        span_y = int'(cfg_shadow.dst_extent[31:16]);
        if (span_x == 0)
            span_x = int'(cfg_shadow.src_extent[15:0]);
        if (span_y == 0)
            span_y = int'(cfg_shadow.src_extent[31:16]);
        for (int i = 0; i < n; i++)
            push_offset(pick_offset(span_x), pick_offset(span_y));
    endtask

    initial
    begin
        cfg_t setup;
        int random_total;
        int n;
        int kind;
        random_total = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // registers still at reset: zero extents, nothing valid
        push_offset(0, 0);
        push_offset(32767, 32767);

        setup.src_origin = {16'd3, 16'd5};
        setup.src_extent = {16'd30, 16'd40};
        setup.dst_origin = {16'd7, 16'd10};
        setup.dst_extent = {16'd60, 16'd80};
        setup.src_geom   = {BPP_2, 16'd48, 16'd64};
        setup.dst_geom   = {BPP_4, 16'd96, 16'd128};
        setup.src_pitch  = 16'd128;
        setup.dst_pitch  = 16'd512;
        load_setup(setup);
        push_offset(0, 0);
        push_offset(79, 59);
        push_offset(80, 0);
        push_offset(0, 60);
        push_offset(40, 30);
        push_offset(1, 1);
        push_offset(32767, 0);
        push_offset(0, 32767);

        // zero source width
        setup.src_extent = {16'd30, 16'd0};
        load_setup(setup);
        push_offset(0, 0);
        push_offset(5, 5);

        // destination extent taken from source, negative origins, spare bytes code
        setup.src_extent = {16'd30, 16'd40};
        setup.dst_extent = '0;
        setup.src_origin = {16'hfffd, 16'hfffe};
        setup.dst_origin = {16'h0000, 16'hffff};
        setup.src_geom   = {BPP_RSVD, 16'd48, 16'd64};
        setup.dst_geom   = {BPP_RSVD, 16'd96, 16'd128};
        load_setup(setup);
        push_offset(0, 0);
        push_offset(3, 2);
        push_offset(39, 29);
        push_offset(40, 0);

        // coordinates past 16 bits and addresses that wrap
        setup.src_origin = {16'h7fff, 16'h7fff};
        setup.src_extent = 32'hffff_ffff;
        setup.dst_origin = {16'h7fff, 16'h7fff};
        setup.dst_extent = {16'h8000, 16'h8000};
        setup.src_geom   = {BPP_4, 16'hffff, 16'hffff};
        setup.dst_geom   = {BPP_4, 16'hffff, 16'hffff};
        setup.src_pitch  = 16'hffff;
        setup.dst_pitch  = 16'hffff;
        load_setup(setup);
        push_offset(16384, 16384);
        push_offset(0, 0);
        push_offset(32767, 32767);
        push_offset(32767, 16384);

        load_setup('1);
        push_offset(0, 0);
        push_offset(32767, 32767);

        // long sink hold-off while the driver keeps offering beats
        load_setup(tidy_setup());
        queue_phase(200);
        random_total += 200;
        stall_arm = 1'b1;

        // a stretch without idling on either side
        load_setup(tidy_setup());
        wait_idle();
        steady = 1'b1;
        queue_phase(150);
        random_total += 150;
        wait_idle();
        steady = 1'b0;

        while (random_total < RANDOM_BEATS)
        begin
            kind = $urandom_range(99);
            if (kind < 65)
                load_setup(tidy_setup());
            else if (kind < 80)
                load_setup(wild_setup());
            else if (kind < 90)
                load_setup('0);
            else
                load_setup('1);
            n = $urandom_range(150, 80);
            if (n > RANDOM_BEATS - random_total)
                n = RANDOM_BEATS - random_total;
            queue_phase(n);
            random_total += n;
        end

        wait_idle();
        repeat (40) @(negedge clk);
        if (expected_pairs.size() != 0)
            $error("%0d predicted beats never arrived", expected_pairs.size());
        if (mismatches == 0 && expected_pairs.size() == 0)
            $display("** scaled_blit_address_generator: PASSED **");
        else
            $display("** scaled_blit_address_generator: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
src/sbag_pkg.sv
src/sbag_regs.sv
src/sbag_front.sv
src/sbag_div.sv
src/sbag_back.sv
src/scaled_blit_address_generator.sv
sim/scaled_blit_address_generator_tb.sv
